### src/bsr_pkg.sv
// bsr_pkg: shared types and constants for the msb-first bitstream reader
// no dependencies; imported by the sequencer and the top level
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

  localparam int unsigned DEFAULT_BUFFER_BYTES = 4096;
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BYTE_BITS  = 8;
  localparam int unsigned FILL_BYTES = 4;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned SHIFT_W    = 6;   // holds 0..32
  localparam int unsigned FILL_W     = 3;   // holds 0..4

  typedef enum logic [2:0] {
    ACT_START  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_GET    = 3'd2,
    ACT_SKIP   = 3'd3,
    ACT_PUT    = 3'd4
  } action_t;

  // datapath operation selected by the current microcode step
  typedef enum logic [3:0] {
    UOP_DISPATCH = 4'b0001,
    UOP_CONSUME  = 4'b0010,
    UOP_REFILL   = 4'b0100,
    UOP_EMIT     = 4'b1000
  } uop_t;

  // status flags from the datapath that the sequencer branches on
  typedef struct packed {
    logic go_consume;
    logic accept;
    logic finish;
    logic need_refill;
    logic fill_done;
    logic out_free;
  } cond_t;

endpackage

`default_nettype wire

### src/bsr_if.sv
// bsr_req_if and bsr_rsp_if: valid/ready channels of the bitstream reader
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface bsr_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  data_byte;
  logic [15:0] bit_count;
  logic [31:0] put_value;

  modport source (output valid, action, data_byte, bit_count, put_value, input ready);
  modport sink   (input valid, action, data_byte, bit_count, put_value, output ready);
endinterface

interface bsr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        ok;
  logic        over_read;

  modport source (output valid, value, ok, over_read, input ready);
  modport sink   (input valid, value, ok, over_read, output ready);
endinterface

`default_nettype wire

### src/bsr_seq.sv
// bsr_seq: microcode sequencer, step register plus control rom with two-way jumps
// depends on bsr_pkg
`timescale 1ns / 1ps
`default_nettype none

module bsr_seq (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bsr_pkg::cond_t cond,
  output bsr_pkg::uop_t      uop
);
  import bsr_pkg::*;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE    = 2'd0;
  localparam step_t STEP_CONSUME = 2'd1;
  localparam step_t STEP_REFILL  = 2'd2;
  localparam step_t STEP_EMIT    = 2'd3;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_GO_CONSUME,
    COND_ACCEPT,
    COND_FINISH,
    COND_NEED_REFILL,
    COND_FILL_DONE,
    COND_OUT_FREE
  } cond_sel_t;

  typedef struct packed {
    uop_t      op;
    cond_sel_t cond_a;
    step_t     target_a;
    cond_sel_t cond_b;
    step_t     target_b;
    step_t     fall;
  } ctrl_word_t;

  // the program
  function automatic ctrl_word_t ucode_rom(input step_t s);
    ctrl_word_t w;
    unique case (s)
      STEP_IDLE:    w = '{UOP_DISPATCH, COND_GO_CONSUME, STEP_CONSUME,
                          COND_ACCEPT, STEP_EMIT, STEP_IDLE};
      STEP_CONSUME: w = '{UOP_CONSUME, COND_FINISH, STEP_EMIT,
                          COND_NEED_REFILL, STEP_REFILL, STEP_CONSUME};
      STEP_REFILL:  w = '{UOP_REFILL, COND_FILL_DONE, STEP_CONSUME,
                          COND_NEVER, STEP_REFILL, STEP_REFILL};
      STEP_EMIT:    w = '{UOP_EMIT, COND_OUT_FREE, STEP_IDLE,
                          COND_NEVER, STEP_EMIT, STEP_EMIT};
    endcase
    return w;
  endfunction

  function automatic logic cond_hit(input cond_sel_t sel, input cond_t c);
    logic hit;
    unique case (sel)
      COND_NEVER:       hit = 1'b0;
      COND_GO_CONSUME:  hit = c.go_consume;
      COND_ACCEPT:      hit = c.accept;
      COND_FINISH:      hit = c.finish;
      COND_NEED_REFILL: hit = c.need_refill;
      COND_FILL_DONE:   hit = c.fill_done;
      COND_OUT_FREE:    hit = c.out_free;
      default:          hit = 1'b0;
    endcase
    return hit;
  endfunction

  step_t      step;
  step_t      step_next;
  ctrl_word_t cw;

  assign cw  = ucode_rom(step);
  assign uop = cw.op;

  always_comb begin
    priority if (cond_hit(cw.cond_a, cond)) begin
      step_next = cw.target_a;
    end else if (cond_hit(cw.cond_b, cond)) begin
      step_next = cw.target_b;
    end else begin
      step_next = cw.fall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

### src/msb_first_bitstream_reader.sv
// msb_first_bitstream_reader: one word at a time; start, append, put and rejected words go from
// the dispatch step straight to the emit step; get and skip run consume steps that take bits
// chunk by chunk from the reservoir, and each refill loads up to four bytes from the byte memory
// one at a time. the next word is taken once the result sits in the output register.
// synchronous reset clears indices, reservoir, flag and sequencer; the byte memory is not
// cleared and holds nothing meaningful until written
`timescale 1ns / 1ps
`default_nettype none

module msb_first_bitstream_reader #(
  parameter int unsigned BUFFER_BYTES = bsr_pkg::DEFAULT_BUFFER_BYTES
) (
  input  wire logic  clk,
  input  wire logic  rst,
  bsr_req_if.sink    req,
  bsr_rsp_if.source  rsp
);
  import bsr_pkg::*;

  localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
  localparam int unsigned IDX_W  = $clog2(BUFFER_BYTES + 1);

  // ---------------------------------------------------------------- state
  logic [IDX_W-1:0]     write_index, write_index_next;
  logic [IDX_W-1:0]     read_index,  read_index_next;
  logic [WORD_BITS-1:0] reservoir,   reservoir_next;   // valid bits left aligned
  logic [SHIFT_W-1:0]   bits_left,   bits_left_next;
  logic                 over_read_flag, over_read_flag_next;

  // per-word working registers
  logic [COUNT_W-1:0]   remaining, remaining_next;     // bits still to take
  logic [WORD_BITS-1:0] acc, acc_next;                 // collected bits, right aligned
  logic                 res_ok, res_ok_next;
  logic                 is_get, is_get_next;
  logic [FILL_W-1:0]    fill_issued, fill_issued_next; // bytes requested in this refill
  logic                 fill_pending, fill_pending_next;

  // byte memory
  logic [BYTE_BITS-1:0] byte_store [BUFFER_BYTES];
  logic [BYTE_BITS-1:0] rd_byte;
  logic                 mem_we, mem_re;

  // output register
  logic                 rsp_valid;
  logic [WORD_BITS-1:0] rsp_value;
  logic                 rsp_ok, rsp_over_read;

  // sequencer link
  uop_t  uop;
  cond_t cond;

  // ---------------------------------------------------------------- status
  logic                 accept, bytes_avail, fill_issue, out_free;
  logic                 get_go, skip_go;
  logic [SHIFT_W-1:0]   take_n;
  logic [SHIFT_W-1:0]   put_n;
  logic [SHIFT_W:0]     put_total;
  logic [SHIFT_W:0]     back_wide;
  logic [2:0]           put_back;
  logic [SHIFT_W-1:0]   put_back_bits;
  logic                 put_fits;

  assign req.ready   = (uop == UOP_DISPATCH);
  assign accept      = req.valid && req.ready;
  assign bytes_avail = (read_index < write_index);
  assign fill_issue  = (fill_issued < FILL_W'(FILL_BYTES)) && bytes_avail;
  assign out_free    = !rsp_valid || rsp.ready;

  // get needs a legal count and a clear flag; skip only a clear flag
  assign get_go  = (req.action == ACT_GET) && !over_read_flag
                   && (req.bit_count <= COUNT_W'(WORD_BITS));
  assign skip_go = (req.action == ACT_SKIP) && !over_read_flag;

  // bits taken in one consume step: the lesser of what is wanted and what is held
  assign take_n = (remaining < COUNT_W'(bits_left)) ? remaining[SHIFT_W-1:0] : bits_left;

  // put-back: whole bytes returned to the store when the reservoir would overflow
  assign put_n     = req.bit_count[SHIFT_W-1:0];
  assign put_total = {1'b0, bits_left} + {1'b0, put_n};
  assign back_wide = (put_total > (SHIFT_W+1)'(WORD_BITS))
                     ? ((put_total - (SHIFT_W+1)'(WORD_BITS - BYTE_BITS + 1)) >> 3)
                     : '0;
  assign put_back      = back_wide[2:0];
  assign put_back_bits = {put_back, 3'b000};
  assign put_fits      = (put_back_bits <= bits_left)
                         && (IDX_W'(put_back) <= read_index);

  always_comb begin
    cond             = '0;
    cond.go_consume  = accept && (get_go || skip_go);
    cond.accept      = accept;
    cond.finish      = (remaining == '0) || ((bits_left == '0) && !bytes_avail);
    cond.need_refill = (remaining != '0) && (bits_left == '0) && bytes_avail;
    cond.fill_done   = !fill_issue;
    cond.out_free    = out_free;
  end

  bsr_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .cond (cond),
    .uop  (uop)
  );

  // ---------------------------------------------------------------- datapath
  always_comb begin
    write_index_next    = write_index;
    read_index_next     = read_index;
    reservoir_next      = reservoir;
    bits_left_next      = bits_left;
    over_read_flag_next = over_read_flag;
    remaining_next      = remaining;
    acc_next            = acc;
    res_ok_next         = res_ok;
    is_get_next         = is_get;
    fill_issued_next    = fill_issued;
    fill_pending_next   = 1'b0;
    mem_we              = 1'b0;
    mem_re              = 1'b0;

    unique case (uop)
      UOP_DISPATCH: begin
        if (accept) begin
          is_get_next    = (req.action == ACT_GET);
          acc_next       = '0;
          remaining_next = req.bit_count;
          res_ok_next    = 1'b0;
          unique case (req.action)
            ACT_START: begin
              write_index_next    = '0;
              read_index_next     = '0;
              reservoir_next      = '0;
              bits_left_next      = '0;
              over_read_flag_next = 1'b0;
              res_ok_next         = 1'b1;
            end
            ACT_APPEND: begin
              if (write_index < IDX_W'(BUFFER_BYTES)) begin
                mem_we           = 1'b1;
                write_index_next = write_index + 1'b1;
                res_ok_next      = 1'b1;
              end
            end
            ACT_PUT: begin
              // count must be 1..32 and the backed-up bytes must still be on hand
              if (!over_read_flag && (req.bit_count != '0)
                  && (req.bit_count <= COUNT_W'(WORD_BITS)) && put_fits) begin
                bits_left_next  = bits_left - put_back_bits + put_n;
                read_index_next = read_index - IDX_W'(put_back);
                reservoir_next  = (reservoir >> put_n)
                                  | (req.put_value << (SHIFT_W'(WORD_BITS) - put_n));
                res_ok_next     = 1'b1;
              end
            end
            default: begin
              // get and skip carry on in the consume step; unknown codes fail
            end
          endcase
        end
      end

      UOP_CONSUME: begin
        if (remaining == '0) begin
          res_ok_next = 1'b1;
        end else if (bits_left == '0) begin
          if (!bytes_avail) begin
            over_read_flag_next = 1'b1;
            res_ok_next         = 1'b0;
          end else begin
            reservoir_next   = '0;
            fill_issued_next = '0;
          end
        end else begin
          acc_next       = (acc << take_n) | (reservoir >> (SHIFT_W'(WORD_BITS) - take_n));
          reservoir_next = reservoir << take_n;
          bits_left_next = bits_left - take_n;
          remaining_next = remaining - COUNT_W'(take_n);
        end
      end

      UOP_REFILL: begin
        // the byte read last cycle lands below those already loaded
        if (fill_pending) begin
          reservoir_next = reservoir
                           | ({rd_byte, {(WORD_BITS - BYTE_BITS){1'b0}}} >> bits_left);
          bits_left_next = bits_left + SHIFT_W'(BYTE_BITS);
        end
        if (fill_issue) begin
          mem_re           = 1'b1;
          read_index_next  = read_index + 1'b1;
          fill_issued_next = fill_issued + 1'b1;
        end
        fill_pending_next = fill_issue;
      end

      UOP_EMIT: begin
        // result waits here until the output register is free
      end

      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      read_index     <= '0;
      reservoir      <= '0;
      bits_left      <= '0;
      over_read_flag <= 1'b0;
      fill_issued    <= '0;
      fill_pending   <= 1'b0;
    end else begin
      write_index    <= write_index_next;
      read_index     <= read_index_next;
      reservoir      <= reservoir_next;
      bits_left      <= bits_left_next;
      over_read_flag <= over_read_flag_next;
      fill_issued    <= fill_issued_next;
      fill_pending   <= fill_pending_next;
    end
  end

  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    acc       <= acc_next;
    res_ok    <= res_ok_next;
    is_get    <= is_get_next;
  end

  // byte memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[write_index[ADDR_W-1:0]] <= req.data_byte;
    end
    if (mem_re) begin
      rd_byte <= byte_store[read_index[ADDR_W-1:0]];
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((uop == UOP_EMIT) && out_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((uop == UOP_EMIT) && out_free) begin
      rsp_value     <= (res_ok && is_get) ? acc : '0;
      rsp_ok        <= res_ok;
      rsp_over_read <= over_read_flag;
    end
  end

  assign rsp.valid     = rsp_valid;
  assign rsp.value     = rsp_value;
  assign rsp.ok        = rsp_ok;
  assign rsp.over_read = rsp_over_read;

endmodule

`default_nettype wire
